>>> hw/rtl/dcc_pkg.sv
`default_nettype none

package dcc_pkg;

	localparam int unsigned LETTERS = 26;
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned PCT_W   = 7;
	localparam int unsigned MAXC_W  = 11;
	localparam int unsigned CHAR_W  = 8;

	localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
	localparam logic [CHAR_W-1:0] CH_U     = 8'h55;
	localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

	// Register indices of the configuration port.
	localparam logic [2:0] REG_PRIMARY   = 3'd0;
	localparam logic [2:0] REG_SECONDARY = 3'd1;
	localparam logic [2:0] REG_TERTIARY  = 3'd2;
	localparam logic [2:0] REG_MODE      = 3'd3;
	localparam logic [2:0] REG_SUB       = 3'd4;
	localparam logic [2:0] REG_PROJECT   = 3'd5;
	localparam logic [2:0] REG_GAP       = 3'd6;

	// Shade modes, substitution styles and project types.
	localparam logic [2:0] MODE_OFF      = 3'd0;
	localparam logic [2:0] MODE_PRI      = 3'd2;
	localparam logic [2:0] MODE_SEC      = 3'd3;
	localparam logic [2:0] MODE_TER      = 3'd4;
	localparam logic [1:0] SUB_PLAIN     = 2'd0;
	localparam logic [1:0] SUB_LOWER     = 2'd1;
	localparam logic [1:0] SUB_LEVEL_ONE = 2'd2;
	localparam logic [2:0] PROJ_PLAIN    = 3'd0;
	localparam logic [2:0] PROJ_FORCE_T  = 3'd3;
	localparam logic [2:0] PROJ_FORCE_U  = 3'd4;

	// Letter indices.
	localparam logic [IDX_W-1:0] IX_A = 5'd0;
	localparam logic [IDX_W-1:0] IX_B = 5'd1;
	localparam logic [IDX_W-1:0] IX_C = 5'd2;
	localparam logic [IDX_W-1:0] IX_D = 5'd3;
	localparam logic [IDX_W-1:0] IX_G = 5'd6;
	localparam logic [IDX_W-1:0] IX_H = 5'd7;
	localparam logic [IDX_W-1:0] IX_K = 5'd10;
	localparam logic [IDX_W-1:0] IX_M = 5'd12;
	localparam logic [IDX_W-1:0] IX_N = 5'd13;
	localparam logic [IDX_W-1:0] IX_R = 5'd17;
	localparam logic [IDX_W-1:0] IX_S = 5'd18;
	localparam logic [IDX_W-1:0] IX_T = 5'd19;
	localparam logic [IDX_W-1:0] IX_U = 5'd20;
	localparam logic [IDX_W-1:0] IX_V = 5'd21;
	localparam logic [IDX_W-1:0] IX_W = 5'd22;
	localparam logic [IDX_W-1:0] IX_X = 5'd23;
	localparam logic [IDX_W-1:0] IX_Y = 5'd24;
	localparam logic [IDX_W-1:0] IX_Z = 5'd25;
	localparam logic [IDX_W-1:0] IX_LAST = 5'd25;

	// One bit per letter.
	localparam logic [LETTERS-1:0] L_A = 26'd1 << 0;
	localparam logic [LETTERS-1:0] L_B = 26'd1 << 1;
	localparam logic [LETTERS-1:0] L_C = 26'd1 << 2;
	localparam logic [LETTERS-1:0] L_D = 26'd1 << 3;
	localparam logic [LETTERS-1:0] L_G = 26'd1 << 6;
	localparam logic [LETTERS-1:0] L_H = 26'd1 << 7;
	localparam logic [LETTERS-1:0] L_K = 26'd1 << 10;
	localparam logic [LETTERS-1:0] L_M = 26'd1 << 12;
	localparam logic [LETTERS-1:0] L_N = 26'd1 << 13;
	localparam logic [LETTERS-1:0] L_R = 26'd1 << 17;
	localparam logic [LETTERS-1:0] L_S = 26'd1 << 18;
	localparam logic [LETTERS-1:0] L_T = 26'd1 << 19;
	localparam logic [LETTERS-1:0] L_U = 26'd1 << 20;
	localparam logic [LETTERS-1:0] L_V = 26'd1 << 21;
	localparam logic [LETTERS-1:0] L_W = 26'd1 << 22;
	localparam logic [LETTERS-1:0] L_X = 26'd1 << 23;
	localparam logic [LETTERS-1:0] L_Y = 26'd1 << 24;

	localparam logic [LETTERS-1:0] L_ALL_CODES = L_A | L_C | L_G | L_T | L_U | L_Y | L_R |
		L_W | L_S | L_K | L_M | L_B | L_D | L_H | L_V | L_N | L_X;

	typedef struct packed {
		logic [PCT_W-1:0]  primary_pct;
		logic [PCT_W-1:0]  secondary_pct;
		logic [PCT_W-1:0]  tertiary_pct;
		logic [2:0]        shade_mode;
		logic [1:0]        sub_style;
		logic [2:0]        project_type;
		logic [CHAR_W-1:0] gap_char;
	} cfg_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  consensus_char;
		logic [1:0]         shade;
		logic [1:0]         row_shade;
		logic [LETTERS-1:0] group_mask;
		logic [MAXC_W-1:0]  max_count;
	} result_t;

	// Letters whose counters a residue letter adds to.
	function automatic logic [LETTERS-1:0] expand_of(input logic [IDX_W-1:0] idx);
		logic [LETTERS-1:0] m;
		m = '0;
		case (idx)
			IX_A: m = L_A;
			IX_B: m = L_C | L_G | L_T | L_B;
			IX_C: m = L_C;
			IX_D: m = L_A | L_G | L_T | L_D;
			IX_G: m = L_G;
			IX_H: m = L_A | L_C | L_T | L_H;
			IX_K: m = L_T | L_G | L_K;
			IX_M: m = L_C | L_A | L_M;
			IX_N: m = L_A | L_C | L_G | L_T | L_N | L_X;
			IX_R: m = L_A | L_G | L_R;
			IX_S: m = L_C | L_G | L_S;
			IX_T: m = L_T;
			IX_U: m = L_T;
			IX_V: m = L_A | L_C | L_G | L_V;
			IX_W: m = L_A | L_T | L_W;
			IX_X: m = L_A | L_C | L_G | L_T | L_N | L_X;
			IX_Y: m = L_C | L_T | L_Y;
			default: m = '0;
		endcase
		return m;
	endfunction

	// Letters that share a group with the consensus letter.
	function automatic logic [LETTERS-1:0] group_of(input logic [IDX_W-1:0] idx);
		logic [LETTERS-1:0] m;
		m = '0;
		case (idx)
			IX_A: m = L_A | L_R | L_W | L_M | L_D | L_H | L_V | L_N | L_X;
			IX_B: m = L_C | L_G | L_T | L_U | L_Y | L_S | L_K | L_B | L_N | L_X;
			IX_C: m = L_C | L_Y | L_S | L_M | L_B | L_H | L_V | L_N | L_X;
			IX_D: m = L_A | L_G | L_T | L_U | L_R | L_W | L_K | L_D | L_N | L_X;
			IX_G: m = L_G | L_R | L_S | L_K | L_B | L_D | L_V | L_N | L_X;
			IX_H: m = L_A | L_C | L_T | L_U | L_Y | L_W | L_M | L_H | L_N | L_X;
			IX_K: m = L_T | L_U | L_G | L_K | L_N | L_X;
			IX_M: m = L_C | L_A | L_M | L_N | L_X;
			IX_N: m = L_ALL_CODES;
			IX_R: m = L_A | L_G | L_R | L_N | L_X;
			IX_S: m = L_C | L_G | L_S | L_N | L_X;
			IX_T: m = L_T | L_U | L_Y | L_W | L_K | L_B | L_D | L_H | L_N | L_X;
			IX_V: m = L_A | L_C | L_G | L_R | L_S | L_M | L_V | L_N | L_X;
			IX_W: m = L_A | L_T | L_U | L_W | L_N | L_X;
			IX_X: m = L_ALL_CODES;
			IX_Y: m = L_C | L_T | L_U | L_Y | L_N | L_X;
			default: m = '0;
		endcase
		return m;
	endfunction

	// Bit of a base letter in the merge code: A, C, G, T from high to low.
	function automatic logic [3:0] base_of(input logic [IDX_W-1:0] idx);
		logic [3:0] b;
		b = 4'b0000;
		case (idx)
			IX_A: b = 4'b1000;
			IX_C: b = 4'b0100;
			IX_G: b = 4'b0010;
			IX_T: b = 4'b0001;
			default: b = 4'b0000;
		endcase
		return b;
	endfunction

	// IUPAC code for a set of tied bases.
	function automatic logic [IDX_W-1:0] merge_of(input logic [3:0] bases);
		logic [IDX_W-1:0] r;
		r = IX_N;
		case (bases)
			4'd1:  r = IX_T;
			4'd2:  r = IX_G;
			4'd3:  r = IX_K;
			4'd4:  r = IX_C;
			4'd5:  r = IX_Y;
			4'd6:  r = IX_S;
			4'd7:  r = IX_B;
			4'd8:  r = IX_A;
			4'd9:  r = IX_W;
			4'd10: r = IX_R;
			4'd11: r = IX_D;
			4'd12: r = IX_M;
			4'd13: r = IX_H;
			4'd14: r = IX_V;
			default: r = IX_N;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dna_column_consensus_shader.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        to block   in_valid / in_ready    residue, last
// out       from block out_valid / out_ready  consensus_char, shade, row_shade,
//                                             group_mask, max_count
// cfg       to block   APB psel/penable       paddr, pwdata, prdata
//
// Rows of a column are taken one item per cycle, while in_ready is high, into
// 26 counter lanes. The item with last set closes the column: a shared
// comparator then scans the 26 counters and a shared multiplier tests the
// three thresholds, and in_ready stays low until the result is emitted.
// The result sits in an output register; a new column may be collected while
// it waits, but the next result is held until that register is free.
// Reset clears the counters and loads the register defaults.

module dna_column_consensus_shader
	import dcc_pkg::*;
#(
	parameter int unsigned MAX_ROWS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [CHAR_W-1:0]  residue,
	input  wire logic               last,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [CHAR_W-1:0]  consensus_char,
	output logic      [1:0]         shade,
	output logic      [1:0]         row_shade,
	output logic      [LETTERS-1:0] group_mask,
	output logic      [MAXC_W-1:0]  max_count
);

	localparam int unsigned CNT_W = $clog2(MAX_ROWS + 1);

	cfg_t             cfg_q;
	logic             wr_en;
	logic             accept;
	logic             collect;
	logic             done;
	logic             out_free;
	logic [IDX_W-1:0] rd_idx;
	logic [CNT_W-1:0] rd_count;
	logic [CNT_W-1:0] rows;
	logic             any_letter;
	result_t          result;
	result_t          out_q;
	logic             out_valid_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.primary_pct   <= 7'd100;
			cfg_q.secondary_pct <= 7'd80;
			cfg_q.tertiary_pct  <= 7'd60;
			cfg_q.shade_mode    <= MODE_TER;
			cfg_q.sub_style     <= SUB_PLAIN;
			cfg_q.project_type  <= PROJ_PLAIN;
			cfg_q.gap_char      <= 8'h20;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_PRIMARY:   cfg_q.primary_pct   <= pwdata[PCT_W-1:0];
				REG_SECONDARY: cfg_q.secondary_pct <= pwdata[PCT_W-1:0];
				REG_TERTIARY:  cfg_q.tertiary_pct  <= pwdata[PCT_W-1:0];
				REG_MODE:      cfg_q.shade_mode    <= pwdata[2:0];
				REG_SUB:       cfg_q.sub_style     <= pwdata[1:0];
				REG_PROJECT:   cfg_q.project_type  <= pwdata[2:0];
				REG_GAP:       cfg_q.gap_char      <= pwdata[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_PRIMARY:   prdata = 32'(cfg_q.primary_pct);
			REG_SECONDARY: prdata = 32'(cfg_q.secondary_pct);
			REG_TERTIARY:  prdata = 32'(cfg_q.tertiary_pct);
			REG_MODE:      prdata = 32'(cfg_q.shade_mode);
			REG_SUB:       prdata = 32'(cfg_q.sub_style);
			REG_PROJECT:   prdata = 32'(cfg_q.project_type);
			REG_GAP:       prdata = 32'(cfg_q.gap_char);
			default:       prdata = '0;
		endcase
	end

	assign in_ready = collect;
	assign accept   = in_valid && collect;
	assign out_free = !out_valid_q || out_ready;

	dcc_counters #(
		.MAX_ROWS (MAX_ROWS),
		.CNT_W    (CNT_W)
	) u_counters (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.residue    (residue),
		.clear      (done),
		.rd_idx     (rd_idx),
		.rd_count   (rd_count),
		.rows       (rows),
		.any_letter (any_letter)
	);

	dcc_resolve #(
		.CNT_W (CNT_W)
	) u_resolve (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.start      (accept && last),
		.out_free   (out_free),
		.rows       (rows),
		.any_letter (any_letter),
		.rd_count   (rd_count),
		.rd_idx     (rd_idx),
		.collect    (collect),
		.done       (done),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign consensus_char = out_q.consensus_char;
	assign shade          = out_q.shade;
	assign row_shade      = out_q.row_shade;
	assign group_mask     = out_q.group_mask;
	assign max_count      = out_q.max_count;

endmodule

`default_nettype wire

>>> hw/rtl/dcc_counters.sv
`default_nettype none

module dcc_counters
	import dcc_pkg::*;
#(
	parameter int unsigned MAX_ROWS = 1024,
	parameter int unsigned CNT_W    = 11
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [CHAR_W-1:0]  residue,
	input  wire logic               clear,
	input  wire logic [IDX_W-1:0]   rd_idx,
	output logic      [CNT_W-1:0]   rd_count,
	output logic      [CNT_W-1:0]   rows,
	output logic                    any_letter
);

	logic [CNT_W-1:0]   count_q [LETTERS];
	logic [CNT_W-1:0]   rows_q;
	logic               any_q;
	logic [CHAR_W-1:0]  ch;
	logic [CHAR_W-1:0]  ofs;
	logic               is_letter;
	logic               room;
	logic [LETTERS-1:0] inc;

	always_comb begin
		ch = residue;
		if (ch >= CH_LA && ch <= CH_LZ) begin
			ch = ch - CASE_OFS;
		end
		ofs = ch - CH_A;
		is_letter = (ch >= CH_A) && (ch <= CH_Z);
		room = rows_q < CNT_W'(MAX_ROWS);
		inc = (accept && room && is_letter) ? expand_of(ofs[IDX_W-1:0]) : '0;
	end

	// Rows beyond the capacity of a column are dropped, but still close it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
			any_q  <= 1'b0;
			for (int i = 0; i < LETTERS; i++) begin
				count_q[i] <= '0;
			end
		end else if (clear) begin
			rows_q <= '0;
			any_q  <= 1'b0;
			for (int i = 0; i < LETTERS; i++) begin
				count_q[i] <= '0;
			end
		end else begin
			if (accept && room) begin
				rows_q <= rows_q + CNT_W'(1);
				if (is_letter) begin
					any_q <= 1'b1;
				end
			end
			for (int i = 0; i < LETTERS; i++) begin
				if (inc[i]) begin
					count_q[i] <= count_q[i] + CNT_W'(1);
				end
			end
		end
	end

	assign rd_count   = count_q[rd_idx];
	assign rows       = rows_q;
	assign any_letter = any_q;

endmodule

`default_nettype wire

>>> hw/rtl/dcc_resolve.sv
`default_nettype none

module dcc_resolve
	import dcc_pkg::*;
#(
	parameter int unsigned CNT_W = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             start,
	input  wire logic             out_free,
	input  wire logic [CNT_W-1:0] rows,
	input  wire logic             any_letter,
	input  wire logic [CNT_W-1:0] rd_count,
	output logic      [IDX_W-1:0] rd_idx,
	output logic                  collect,
	output logic                  done,
	output result_t               result
);

	localparam int unsigned PW = CNT_W + PCT_W;

	localparam logic [1:0] TH_LIM = 2'd0;
	localparam logic [1:0] TH_PRI = 2'd1;
	localparam logic [1:0] TH_SEC = 2'd2;
	localparam logic [1:0] TH_TER = 2'd3;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_SCAN,
		ST_THRESH,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] maxc_q;
	logic [1:0]       ties_q;
	logic [3:0]       bases_q;
	logic [IDX_W-1:0] first_q;
	logic [IDX_W-1:0] alt_q;
	logic             alt_vld_q;
	logic [1:0]       thr_q;
	logic [PW-1:0]    lim_q;
	logic [2:0]       ge_q;

	logic             gt;
	logic             eq;
	logic [3:0]       bbit;
	logic [PCT_W-1:0] pct;
	logic [PW-1:0]    prod;

	// The one compare unit of the scan, and the one rows-by-percentage multiplier
	// of the threshold steps.
	always_comb begin
		gt   = rd_count > maxc_q;
		eq   = rd_count == maxc_q;
		bbit = base_of(idx_q);
		case (thr_q)
			TH_PRI:  pct = cfg.primary_pct;
			TH_SEC:  pct = cfg.secondary_pct;
			TH_TER:  pct = cfg.tertiary_pct;
			default: pct = cfg.tertiary_pct;
		endcase
		prod = PW'(rows) * PW'(pct);
	end

	// maxc reaches (rows*pct+50)/100 exactly when rows*pct < 100*maxc+50.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_COLLECT;
			idx_q     <= '0;
			maxc_q    <= '0;
			ties_q    <= '0;
			bases_q   <= '0;
			first_q   <= '0;
			alt_q     <= '0;
			alt_vld_q <= 1'b0;
			thr_q     <= TH_LIM;
			lim_q     <= '0;
			ge_q      <= '0;
		end else begin
			case (state_q)
				ST_COLLECT: begin
					if (start) begin
						state_q   <= ST_SCAN;
						idx_q     <= '0;
						maxc_q    <= '0;
						ties_q    <= '0;
						bases_q   <= '0;
						alt_vld_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (gt) begin
						maxc_q    <= rd_count;
						ties_q    <= 2'd1;
						first_q   <= idx_q;
						bases_q   <= bbit;
						alt_q     <= idx_q;
						alt_vld_q <= bbit == 4'b0000;
					end else if (eq) begin
						if (ties_q == 2'd0) begin
							first_q <= idx_q;
						end
						if (ties_q != 2'd2) begin
							ties_q <= ties_q + 2'd1;
						end
						bases_q <= bases_q | bbit;
						if (bbit == 4'b0000 && !alt_vld_q) begin
							alt_q     <= idx_q;
							alt_vld_q <= 1'b1;
						end
					end
					if (idx_q == IX_LAST) begin
						state_q <= ST_THRESH;
						thr_q   <= TH_LIM;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_THRESH: begin
					case (thr_q)
						TH_LIM:  lim_q <= PW'(maxc_q) * PW'(100) + PW'(50);
						TH_PRI:  ge_q[2] <= prod < lim_q;
						TH_SEC:  ge_q[1] <= prod < lim_q;
						default: ge_q[0] <= prod < lim_q;
					endcase
					if (thr_q == TH_TER) begin
						state_q <= ST_EMIT;
					end
					thr_q <= thr_q + 2'd1;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_COLLECT;
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	logic               emit;
	logic [IDX_W-1:0]   pick;
	logic [LETTERS-1:0] gmask;
	logic               multi;
	logic [1:0]         lvl;
	logic [1:0]         rlvl;
	logic               pass;
	logic [CHAR_W-1:0]  cons;

	always_comb begin
		emit = (state_q == ST_EMIT) && out_free;
		if (ties_q == 2'd1) begin
			pick = first_q;
		end else if (alt_vld_q) begin
			pick = alt_q;
		end else begin
			pick = merge_of(bases_q);
		end
		gmask = group_of(pick);
		multi = (gmask & (gmask - LETTERS'(1))) != '0;

		if (ge_q[2]) begin
			lvl = 2'd3;
		end else if (ge_q[1]) begin
			lvl = 2'd2;
		end else if (ge_q[0]) begin
			lvl = 2'd1;
		end else begin
			lvl = 2'd0;
		end

		case (cfg.shade_mode)
			MODE_TER: pass = ge_q[0];
			MODE_SEC: pass = ge_q[1];
			MODE_PRI: pass = ge_q[2];
			default:  pass = 1'b1;
		endcase

		rlvl = lvl;
		if (cfg.sub_style == SUB_LOWER) begin
			if (multi && lvl != 2'd0) begin
				rlvl = lvl - 2'd1;
			end
		end else if (cfg.sub_style == SUB_LEVEL_ONE) begin
			if (multi) begin
				rlvl = (lvl != 2'd1) ? 2'd1 : 2'd0;
			end else if (lvl == 2'd1) begin
				rlvl = 2'd0;
			end
		end

		cons = CH_A + CHAR_W'(pick);
		if (cons == CH_T || cons == CH_U) begin
			if (cfg.project_type == PROJ_FORCE_T) begin
				cons = CH_T;
			end else if (cfg.project_type == PROJ_FORCE_U) begin
				cons = CH_U;
			end
		end
		if (lvl != 2'd3) begin
			cons = cons + CASE_OFS;
		end

		if (!any_letter) begin
			result = '0;
			result.consensus_char = cfg.gap_char;
		end else begin
			result.shade          = lvl;
			result.row_shade      = (pass && cfg.shade_mode != MODE_OFF) ? rlvl : 2'd0;
			result.group_mask     = gmask;
			result.max_count      = MAXC_W'(maxc_q);
			result.consensus_char = (pass && lvl[1]) ? cons : cfg.gap_char;
		end
	end

	assign rd_idx  = idx_q;
	assign collect = state_q == ST_COLLECT;
	assign done    = emit;

endmodule

`default_nettype wire
